// ----- sv/epoch_flag_event_segmenter_assert.svh -----
// assertion macros for the epoch flag event segmenter
`ifndef EPOCH_FLAG_EVENT_SEGMENTER_ASSERT_SVH
`define EPOCH_FLAG_EVENT_SEGMENTER_ASSERT_SVH

// same cycle implication
`define EFES_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("efes assertion failed");

// next cycle implication
`define EFES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("efes assertion failed");

`endif

// ----- sv/efes_pkg.sv -----
// ----------------------------------------------------------------------------
// efes_pkg
// Shared types, widths and codes of the epoch flag event segmenter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efes_pkg;

	localparam int FEAT_BITS         = 24;
	localparam int WINDOW_DEPTH_DEF  = 256;
	localparam int TIME_W            = 32;
	localparam int CH_W              = 8;
	localparam int PEAK_W            = 16;
	localparam int TOTAL_W           = 16;
	localparam int EL_W              = 20;
	localparam int DUR_W             = 24;
	localparam int LIM_W             = 9;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 24;

	localparam logic [EL_W-1:0]  EPOCH_LENGTH_RST = 20'd5000;
	localparam logic [DUR_W-1:0] MIN_DURATION_RST = 24'd0;
	localparam logic [DUR_W-1:0] MAX_DURATION_RST = 24'd200000;
	localparam logic [DUR_W-1:0] MIN_GAP_RST      = 24'd5000;
	localparam logic [LIM_W-1:0] WINDOW_LIMIT_RST = 9'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EPOCH_LENGTH,
		REG_MIN_DURATION,
		REG_MAX_DURATION,
		REG_MIN_GAP,
		REG_WINDOW_LIMIT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OUT_NEW,
		OUT_MERGED,
		OUT_SHORT,
		OUT_LONG
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PUSH,
		ST_STATS,
		ST_DECIDE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		WS_IDLE,
		WS_READ,
		WS_UPDATE
	} win_state_t;

	typedef enum logic [2:0] {
		SS_IDLE,
		SS_MUL,
		SS_SUB,
		SS_DIV,
		SS_SQRT
	} stats_state_t;

	typedef struct packed {
		logic                 record_start;
		logic                 is_event_epoch;
		logic [TIME_W-1:0]    epoch_time;
		logic [CH_W-1:0]      channel;
		logic [FEAT_BITS-1:0] amplitude;
		logic [FEAT_BITS-1:0] power;
		logic [PEAK_W-1:0]    spectral_peak;
	} in_t;

	typedef struct packed {
		logic [1:0]           outcome;
		logic [CH_W-1:0]      det_channel;
		logic [TIME_W-1:0]    start_time;
		logic [TIME_W-1:0]    end_time;
		logic [FEAT_BITS-1:0] max_amplitude;
		logic [FEAT_BITS-1:0] max_power;
		logic [PEAK_W-1:0]    max_spectral_peak;
		logic [FEAT_BITS-1:0] bg_amplitude;
		logic [FEAT_BITS-1:0] bg_power;
		logic [FEAT_BITS-1:0] bg_std_dev;
		logic [TOTAL_W-1:0]   short_total;
		logic [TOTAL_W-1:0]   long_total;
	} out_t;

	typedef struct packed {
		logic clear;
		logic push;
	} win_cmd_t;

	typedef struct packed {
		logic [FEAT_BITS-1:0] bg_amp;
		logic [FEAT_BITS-1:0] bg_pow;
		logic [FEAT_BITS-1:0] bg_std;
	} stats_res_t;

endpackage

// ----- sv/efes_stream_if.sv -----
// ----------------------------------------------------------------------------
// efes_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface efes_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/efes_window.sv -----
// ----------------------------------------------------------------------------
// efes_window
// Background window memory with running sums of amplitude, power and power
// squared; each push drops the oldest entry at the limit and appends one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efes_window #(
	parameter int DEPTH = efes_pkg::WINDOW_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int SW = efes_pkg::FEAT_BITS + CW,
	localparam int QW = 2 * efes_pkg::FEAT_BITS + CW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  efes_pkg::win_cmd_t             cmd,
	input  logic [efes_pkg::FEAT_BITS-1:0] amp,
	input  logic [efes_pkg::FEAT_BITS-1:0] pow,
	input  logic [efes_pkg::LIM_W-1:0]     limit,
	output logic                           done,
	output logic [CW-1:0]                  count,
	output logic [SW-1:0]                  sum_amp,
	output logic [SW-1:0]                  sum_pow,
	output logic [QW-1:0]                  sum_sq
);
	localparam int F  = efes_pkg::FEAT_BITS;
	localparam int LW = (CW > efes_pkg::LIM_W) ? CW : efes_pkg::LIM_W;

	logic [2*F-1:0] mem [DEPTH];
	logic [2*F-1:0] rd_data_q;

	efes_pkg::win_state_t state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] sum_amp_q, sum_pow_q;
	logic [QW-1:0] sum_sq_q;
	logic [F-1:0]   new_amp_q, new_pow_q;
	logic [2*F-1:0] new_sq_q, old_sq_q;
	logic           drop_q;

	logic [LW-1:0] lim_raw, lim;
	logic          drop;
	logic [CW:0]   pos_sum, head_inc;
	logic [AW-1:0] pos, head_next;
	logic [F-1:0]  old_amp, old_pow;

	always_comb begin
		lim_raw = LW'(limit);
		if (lim_raw == '0) begin
			lim = LW'(1);
		end else if (lim_raw > LW'(DEPTH)) begin
			lim = LW'(DEPTH);
		end else begin
			lim = lim_raw;
		end
		drop = (LW'(count_q) >= lim) && (count_q != '0);
		pos_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
		if (pos_sum >= (CW+1)'(DEPTH)) begin
			pos_sum = pos_sum - (CW+1)'(DEPTH);
		end
		pos = pos_sum[AW-1:0];
		head_inc = (CW+1)'(head_q) + (CW+1)'(1);
		if (head_inc >= (CW+1)'(DEPTH)) begin
			head_inc = '0;
		end
		head_next = head_inc[AW-1:0];
		old_amp = rd_data_q[2*F-1:F];
		old_pow = rd_data_q[F-1:0];
	end

	// memory port: read the oldest entry on push, write the new one on update
	always_ff @(posedge clk) begin
		if (state_q == efes_pkg::WS_IDLE && cmd.push) begin
			rd_data_q <= mem[head_q];
		end
		if (state_q == efes_pkg::WS_UPDATE) begin
			mem[pos] <= {new_amp_q, new_pow_q};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == efes_pkg::WS_IDLE && cmd.push) begin
			new_amp_q <= amp;
			new_pow_q <= pow;
			new_sq_q  <= (2*F)'(pow) * (2*F)'(pow);
			drop_q    <= drop;
		end
		if (state_q == efes_pkg::WS_READ) begin
			old_sq_q <= (2*F)'(old_pow) * (2*F)'(old_pow);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= efes_pkg::WS_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			sum_amp_q <= '0;
			sum_pow_q <= '0;
			sum_sq_q  <= '0;
		end else begin
			case (state_q)
				efes_pkg::WS_IDLE: begin
					if (cmd.clear) begin
						head_q    <= '0;
						count_q   <= '0;
						sum_amp_q <= '0;
						sum_pow_q <= '0;
						sum_sq_q  <= '0;
					end else if (cmd.push) begin
						state_q <= efes_pkg::WS_READ;
					end
				end
				efes_pkg::WS_READ: begin
					state_q <= efes_pkg::WS_UPDATE;
				end
				efes_pkg::WS_UPDATE: begin
					state_q <= efes_pkg::WS_IDLE;
					if (drop_q) begin
						head_q    <= head_next;
						sum_amp_q <= sum_amp_q - SW'(old_amp) + SW'(new_amp_q);
						sum_pow_q <= sum_pow_q - SW'(old_pow) + SW'(new_pow_q);
						sum_sq_q  <= sum_sq_q - QW'(old_sq_q) + QW'(new_sq_q);
					end else begin
						count_q   <= count_q + CW'(1);
						sum_amp_q <= sum_amp_q + SW'(new_amp_q);
						sum_pow_q <= sum_pow_q + SW'(new_pow_q);
						sum_sq_q  <= sum_sq_q + QW'(new_sq_q);
					end
				end
				default: begin
					state_q <= efes_pkg::WS_IDLE;
				end
			endcase
		end
	end

	assign done    = (state_q == efes_pkg::WS_UPDATE);
	assign count   = count_q;
	assign sum_amp = sum_amp_q;
	assign sum_pow = sum_pow_q;
	assign sum_sq  = sum_sq_q;

endmodule

// ----- sv/efes_stats.sv -----
// ----------------------------------------------------------------------------
// efes_stats
// Serial background statistics: shift-add products, restoring divisions for
// the means and the variance, then a two-bit-per-step square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efes_stats #(
	parameter int DEPTH = efes_pkg::WINDOW_DEPTH_DEF,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int SW = efes_pkg::FEAT_BITS + CW,
	localparam int QW = 2 * efes_pkg::FEAT_BITS + CW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [CW-1:0]        n,
	input  logic [SW-1:0]        sum_amp,
	input  logic [SW-1:0]        sum_pow,
	input  logic [QW-1:0]        sum_sq,
	output logic                 done,
	output efes_pkg::stats_res_t res
);
	localparam int F  = efes_pkg::FEAT_BITS;
	localparam int NW = 2 * F + 2 * CW;
	localparam int IW = $clog2(NW + 1);

	efes_pkg::stats_state_t state_q;
	logic [IW-1:0] iter_q;
	logic          done_q;

	logic [NW-1:0]   acc_a_q, acc_b_q, mca_q, mcb_q;
	logic [CW-1:0]   mpa_q, n_q;
	logic [SW-1:0]   mpb_q;
	logic [2*CW-1:0] nsq_q, remv_q;
	logic [CW-1:0]   rema_q, remp_q;
	logic [NW-1:0]   dvv_q, dva_q, dvp_q;
	logic [2*F-1:0]  x_q;
	logic [F:0]      rems_q;
	logic [F-1:0]    root_q;
	efes_pkg::stats_res_t res_q;

	logic [NW-1:0]   acc_a_n, acc_b_n;
	logic [2*CW:0]   vtrial;
	logic [CW:0]     atrial, ptrial;
	logic            v_ge, a_ge, p_ge, s_ge;
	logic [NW-1:0]   dvv_n, dva_n, dvp_n;
	logic [F+2:0]    strial, ssub, srem;
	logic [F-1:0]    root_n;

	always_comb begin
		acc_a_n = mpa_q[0] ? acc_a_q + mca_q : acc_a_q;
		acc_b_n = mpb_q[0] ? acc_b_q + mcb_q : acc_b_q;
		vtrial  = {remv_q, dvv_q[NW-1]};
		atrial  = {rema_q, dva_q[NW-1]};
		ptrial  = {remp_q, dvp_q[NW-1]};
		v_ge    = vtrial >= {1'b0, nsq_q};
		a_ge    = atrial >= {1'b0, n_q};
		p_ge    = ptrial >= {1'b0, n_q};
		dvv_n   = {dvv_q[NW-2:0], v_ge};
		dva_n   = {dva_q[NW-2:0], a_ge};
		dvp_n   = {dvp_q[NW-2:0], p_ge};
		strial  = {rems_q, x_q[2*F-1:2*F-2]};
		ssub    = {1'b0, root_q, 2'b01};
		s_ge    = strial >= ssub;
		srem    = s_ge ? strial - ssub : strial;
		root_n  = {root_q[F-2:0], s_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efes_pkg::SS_IDLE;
			iter_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				efes_pkg::SS_IDLE: begin
					if (start) begin
						if (n == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= efes_pkg::SS_MUL;
							iter_q  <= IW'(SW);
						end
					end
				end
				efes_pkg::SS_MUL: begin
					iter_q <= iter_q - IW'(1);
					if (iter_q == IW'(1)) begin
						state_q <= efes_pkg::SS_SUB;
					end
				end
				efes_pkg::SS_SUB: begin
					state_q <= efes_pkg::SS_DIV;
					iter_q  <= IW'(NW);
				end
				efes_pkg::SS_DIV: begin
					iter_q <= iter_q - IW'(1);
					if (iter_q == IW'(1)) begin
						state_q <= efes_pkg::SS_SQRT;
						iter_q  <= IW'(F);
					end
				end
				efes_pkg::SS_SQRT: begin
					iter_q <= iter_q - IW'(1);
					if (iter_q == IW'(1)) begin
						state_q <= efes_pkg::SS_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= efes_pkg::SS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			efes_pkg::SS_IDLE: begin
				if (start) begin
					if (n == '0) begin
						res_q <= '0;
					end else begin
						acc_a_q <= '0;
						acc_b_q <= '0;
						mca_q   <= NW'(sum_sq);
						mcb_q   <= NW'(sum_pow);
						mpa_q   <= n;
						mpb_q   <= sum_pow;
						n_q     <= n;
						nsq_q   <= (2*CW)'(n) * (2*CW)'(n);
						dva_q   <= NW'(sum_amp);
						dvp_q   <= NW'(sum_pow);
					end
				end
			end
			efes_pkg::SS_MUL: begin
				acc_a_q <= acc_a_n;
				acc_b_q <= acc_b_n;
				mca_q   <= {mca_q[NW-2:0], 1'b0};
				mcb_q   <= {mcb_q[NW-2:0], 1'b0};
				mpa_q   <= mpa_q >> 1;
				mpb_q   <= mpb_q >> 1;
			end
			efes_pkg::SS_SUB: begin
				dvv_q  <= (acc_a_q >= acc_b_q) ? acc_a_q - acc_b_q : '0;
				remv_q <= '0;
				rema_q <= '0;
				remp_q <= '0;
			end
			efes_pkg::SS_DIV: begin
				remv_q <= v_ge ? (2*CW)'(vtrial - {1'b0, nsq_q}) : (2*CW)'(vtrial);
				rema_q <= a_ge ? CW'(atrial - {1'b0, n_q}) : CW'(atrial);
				remp_q <= p_ge ? CW'(ptrial - {1'b0, n_q}) : CW'(ptrial);
				dvv_q  <= dvv_n;
				dva_q  <= dva_n;
				dvp_q  <= dvp_n;
				if (iter_q == IW'(1)) begin
					res_q.bg_amp <= dva_n[F-1:0];
					res_q.bg_pow <= dvp_n[F-1:0];
					x_q          <= dvv_n[2*F-1:0];
					rems_q       <= '0;
					root_q       <= '0;
				end
			end
			efes_pkg::SS_SQRT: begin
				rems_q <= srem[F:0];
				root_q <= root_n;
				x_q    <= {x_q[2*F-3:0], 2'b00};
				if (iter_q == IW'(1)) begin
					res_q.bg_std <= root_n;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- sv/epoch_flag_event_segmenter.sv -----
// ----------------------------------------------------------------------------
// epoch_flag_event_segmenter
// An epoch is taken in IDLE and evaluated in EVAL; a background epoch is then
// pushed into the window, and an epoch closing a run waits in STATS for the
// serial multiply, divide and square root unit (an empty window skips it and
// gives zero statistics), then in DECIDE until the output slot is free.
// Reset clears the control and run state and loads register defaults; data
// registers and window memory are not reset, with no memory clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_flag_event_segmenter #(
	parameter int WINDOW_DEPTH = efes_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	efes_stream_if.sink                     in_item,
	efes_stream_if.source                   out_item,
	input  logic                            cfg_wr_en,
	input  logic [efes_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
	input  logic [efes_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
	`include "epoch_flag_event_segmenter_assert.svh"

	localparam int F  = efes_pkg::FEAT_BITS;
	localparam int TW = efes_pkg::TIME_W;
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = F + CW;
	localparam int QW = 2 * F + CW;

	// configuration
	logic [efes_pkg::EL_W-1:0]  epoch_length_q;
	logic [efes_pkg::DUR_W-1:0] min_duration_q, max_duration_q, min_gap_q;
	logic [efes_pkg::LIM_W-1:0] window_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_length_q <= efes_pkg::EPOCH_LENGTH_RST;
			min_duration_q <= efes_pkg::MIN_DURATION_RST;
			max_duration_q <= efes_pkg::MAX_DURATION_RST;
			min_gap_q      <= efes_pkg::MIN_GAP_RST;
			window_limit_q <= efes_pkg::WINDOW_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (efes_pkg::cfg_reg_t'(cfg_wr_index))
				efes_pkg::REG_EPOCH_LENGTH: epoch_length_q <= cfg_wr_data[efes_pkg::EL_W-1:0];
				efes_pkg::REG_MIN_DURATION: min_duration_q <= cfg_wr_data;
				efes_pkg::REG_MAX_DURATION: max_duration_q <= cfg_wr_data;
				efes_pkg::REG_MIN_GAP:      min_gap_q      <= cfg_wr_data;
				efes_pkg::REG_WINDOW_LIMIT: window_limit_q <= cfg_wr_data[efes_pkg::LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control and run state
	efes_pkg::ctrl_state_t state_q, state_d;
	efes_pkg::in_t         item_q;
	logic                  in_event_q, have_last_q, out_valid_q;
	logic [TW-1:0]         event_start_q, end_q;
	logic [F-1:0]          run_amp_q, run_pow_q;
	logic [efes_pkg::PEAK_W-1:0] run_peak_q;
	logic [efes_pkg::CH_W-1:0]   last_channel_q;
	logic [TW-1:0]               last_start_q, last_end_q;
	logic [F-1:0]                last_amp_q, last_pow_q;
	logic [efes_pkg::PEAK_W-1:0] last_peak_q;
	efes_pkg::stats_res_t        last_bg_q;
	logic [efes_pkg::TOTAL_W-1:0] short_q, long_q;
	efes_pkg::out_t              out_q;

	efes_pkg::win_cmd_t   win_cmd;
	logic                 win_done, stats_start, stats_done;
	logic [CW-1:0]        win_count;
	logic [SW-1:0]        win_sum_amp, win_sum_pow;
	logic [QW-1:0]        win_sum_sq;
	efes_pkg::stats_res_t stats_res;

	logic         in_fire, out_fire, slot_free;
	logic [TW:0]  edge_diff;
	logic [TW-1:0] edge_time;
	logic [TW+1:0] start_min, start_max, last_gap, last_max;
	logic         is_short, is_long, do_merge, cap_over;
	logic [TW-1:0] cap_sat, m_end;
	logic [F-1:0]  m_amp, m_pow;
	logic [efes_pkg::PEAK_W-1:0] m_peak;
	logic [efes_pkg::TOTAL_W-1:0] short_n, long_n;
	efes_pkg::out_t out_d;

	assign in_fire   = in_item.valid && in_item.ready;
	assign out_fire  = out_item.valid && out_item.ready;
	assign slot_free = !out_valid_q || out_item.ready;

	always_comb begin
		edge_diff = {1'b0, item_q.epoch_time} - (TW+1)'(epoch_length_q);
		edge_time = edge_diff[TW] ? '0 : edge_diff[TW-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			efes_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = efes_pkg::ST_EVAL;
				end
			end
			efes_pkg::ST_EVAL: begin
				if (win_cmd.push) begin
					state_d = efes_pkg::ST_PUSH;
				end else if (stats_start) begin
					state_d = efes_pkg::ST_STATS;
				end else begin
					state_d = efes_pkg::ST_IDLE;
				end
			end
			efes_pkg::ST_PUSH: begin
				if (win_done) begin
					state_d = efes_pkg::ST_IDLE;
				end
			end
			efes_pkg::ST_STATS: begin
				if (stats_done) begin
					state_d = efes_pkg::ST_DECIDE;
				end
			end
			efes_pkg::ST_DECIDE: begin
				if (slot_free) begin
					state_d = efes_pkg::ST_IDLE;
				end
			end
			default: state_d = efes_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_item.ready = (state_q == efes_pkg::ST_IDLE);
		win_cmd.clear = (state_q == efes_pkg::ST_EVAL) && item_q.record_start;
		win_cmd.push  = (state_q == efes_pkg::ST_EVAL) && !item_q.record_start &&
			!item_q.is_event_epoch && !in_event_q;
		stats_start   = (state_q == efes_pkg::ST_EVAL) && !item_q.record_start &&
			!item_q.is_event_epoch && in_event_q;
	end

	// detection decision
	always_comb begin
		start_min = (TW+2)'(event_start_q) + (TW+2)'(min_duration_q);
		start_max = (TW+2)'(event_start_q) + (TW+2)'(max_duration_q);
		last_gap  = (TW+2)'(last_end_q) + (TW+2)'(min_gap_q);
		last_max  = (TW+2)'(last_start_q) + (TW+2)'(max_duration_q);
		is_short  = (TW+2)'(end_q) < start_min;
		is_long   = (TW+2)'(end_q) > start_max;
		do_merge  = have_last_q && ((TW+2)'(event_start_q) < last_gap);
		cap_over  = (TW+2)'(end_q) > last_max;
		cap_sat   = (last_max[TW+1:TW] != 2'b00) ? '1 : last_max[TW-1:0];
		m_end     = cap_over ? cap_sat : end_q;
		m_amp     = (run_amp_q > last_amp_q) ? run_amp_q : last_amp_q;
		m_pow     = (run_pow_q > last_pow_q) ? run_pow_q : last_pow_q;
		m_peak    = (run_peak_q > last_peak_q) ? run_peak_q : last_peak_q;
		short_n   = (short_q == '1) ? short_q : short_q + 1'b1;
		long_n    = (long_q == '1) ? long_q : long_q + 1'b1;

		out_d.det_channel       = item_q.channel;
		out_d.start_time        = event_start_q;
		out_d.end_time          = end_q;
		out_d.max_amplitude     = run_amp_q;
		out_d.max_power         = run_pow_q;
		out_d.max_spectral_peak = run_peak_q;
		out_d.bg_amplitude      = stats_res.bg_amp;
		out_d.bg_power          = stats_res.bg_pow;
		out_d.bg_std_dev        = stats_res.bg_std;
		out_d.short_total       = short_q;
		out_d.long_total        = long_q;
		if (is_short) begin
			out_d.outcome     = efes_pkg::OUT_SHORT;
			out_d.short_total = short_n;
		end else if (is_long) begin
			out_d.outcome    = efes_pkg::OUT_LONG;
			out_d.long_total = long_n;
		end else if (do_merge) begin
			out_d.outcome           = efes_pkg::OUT_MERGED;
			out_d.det_channel       = last_channel_q;
			out_d.start_time        = last_start_q;
			out_d.end_time          = m_end;
			out_d.max_amplitude     = m_amp;
			out_d.max_power         = m_pow;
			out_d.max_spectral_peak = m_peak;
			out_d.bg_amplitude      = last_bg_q.bg_amp;
			out_d.bg_power          = last_bg_q.bg_pow;
			out_d.bg_std_dev        = last_bg_q.bg_std;
		end else begin
			out_d.outcome = efes_pkg::OUT_NEW;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_item.payload;
		end
		if (stats_start) begin
			end_q <= edge_time;
		end
		if (state_q == efes_pkg::ST_DECIDE && slot_free) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= efes_pkg::ST_IDLE;
			out_valid_q    <= 1'b0;
			in_event_q     <= 1'b0;
			event_start_q  <= '0;
			run_amp_q      <= '0;
			run_pow_q      <= '0;
			run_peak_q     <= '0;
			have_last_q    <= 1'b0;
			last_channel_q <= '0;
			last_start_q   <= '0;
			last_end_q     <= '0;
			last_amp_q     <= '0;
			last_pow_q     <= '0;
			last_peak_q    <= '0;
			last_bg_q      <= '0;
			short_q        <= '0;
			long_q         <= '0;
		end else begin
			state_q <= state_d;
			if (out_fire && !(state_q == efes_pkg::ST_DECIDE && slot_free)) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == efes_pkg::ST_EVAL) begin
				if (item_q.record_start) begin
					in_event_q    <= 1'b0;
					event_start_q <= '0;
					run_amp_q     <= '0;
					run_pow_q     <= '0;
					run_peak_q    <= '0;
				end else if (item_q.is_event_epoch) begin
					if (!in_event_q) begin
						event_start_q <= edge_time;
						in_event_q    <= 1'b1;
					end
					if (item_q.amplitude > run_amp_q) run_amp_q <= item_q.amplitude;
					if (item_q.power > run_pow_q) run_pow_q <= item_q.power;
					if (item_q.spectral_peak > run_peak_q) run_peak_q <= item_q.spectral_peak;
				end else if (in_event_q) begin
					in_event_q <= 1'b0;
				end
			end
			if (state_q == efes_pkg::ST_DECIDE && slot_free) begin
				out_valid_q <= 1'b1;
				run_amp_q   <= '0;
				run_pow_q   <= '0;
				run_peak_q  <= '0;
				if (is_short) begin
					short_q <= short_n;
				end else if (is_long) begin
					long_q <= long_n;
				end else if (do_merge) begin
					last_end_q  <= m_end;
					last_amp_q  <= m_amp;
					last_pow_q  <= m_pow;
					last_peak_q <= m_peak;
				end else begin
					have_last_q    <= 1'b1;
					last_channel_q <= item_q.channel;
					last_start_q   <= event_start_q;
					last_end_q     <= end_q;
					last_amp_q     <= run_amp_q;
					last_pow_q     <= run_pow_q;
					last_peak_q    <= run_peak_q;
					last_bg_q      <= stats_res;
				end
			end
		end
	end

	assign out_item.valid   = out_valid_q;
	assign out_item.payload = out_q;

	efes_window #(
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (win_cmd),
		.amp     (item_q.amplitude),
		.pow     (item_q.power),
		.limit   (window_limit_q),
		.done    (win_done),
		.count   (win_count),
		.sum_amp (win_sum_amp),
		.sum_pow (win_sum_pow),
		.sum_sq  (win_sum_sq)
	);

	efes_stats #(
		.DEPTH(WINDOW_DEPTH)
	) u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (stats_start),
		.n       (win_count),
		.sum_amp (win_sum_amp),
		.sum_pow (win_sum_pow),
		.sum_sq  (win_sum_sq),
		.done    (stats_done),
		.res     (stats_res)
	);

	`EFES_ASSERT_IMPLIES(a_stats_done_in_wait, stats_done, state_q == efes_pkg::ST_STATS)
	`EFES_ASSERT_IMPLIES(a_win_count_bound, 1'b1, win_count <= CW'(WINDOW_DEPTH))
	`EFES_ASSERT_NEXT(a_accept_to_eval, in_fire, state_q == efes_pkg::ST_EVAL)
	`EFES_ASSERT_NEXT(a_out_drains, out_fire && state_q != efes_pkg::ST_DECIDE, !out_valid_q)

endmodule
